// ===== rtl/itl_pkg.sv =====
`timescale 1ns / 1ps

package itl_pkg;

    // Defaults for the top-level parameters
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int TIME_BITS_DEF   = 32;

    // Fixed field widths of the request and result channels
    localparam int FIELD_TIME_W  = 32;
    localparam int FIELD_LIMIT_W = 11;
    localparam int FIELD_INDEX_W = 10;
    localparam int FIELD_COUNT_W = 11;
    localparam int FIELD_STAT_W  = 2;

    // Depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;

    // Result status codes
    localparam logic [FIELD_STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [FIELD_STAT_W-1:0] STAT_BAD_ORDER = 2'd1;
    localparam logic [FIELD_STAT_W-1:0] STAT_FULL      = 2'd2;

    // Request kinds
    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_LOOKUP = 1'b1
    } itl_op_t;

endpackage

// ===== rtl/itl_ram.sv =====
`timescale 1ns / 1ps

module itl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/itl_front.sv =====
`timescale 1ns / 1ps

module itl_front #(
    parameter int TIME_BITS = itl_pkg::TIME_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_req_type,
    input  logic [itl_pkg::FIELD_TIME_W-1:0]   s_start_time,
    input  logic [itl_pkg::FIELD_TIME_W-1:0]   s_end_time,
    input  logic [itl_pkg::FIELD_TIME_W-1:0]   s_query_time,
    output logic                               cmd_valid,
    input  logic                               cmd_ready,
    output itl_pkg::itl_op_t                   cmd_op,
    output logic [TIME_BITS-1:0]               cmd_time_a,
    output logic [TIME_BITS-1:0]               cmd_time_b
);

    import itl_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    itl_op_t              op_q     [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] time_a_q [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] time_b_q [QUEUE_DEPTH];

    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    logic    push;
    logic    pop;
    itl_op_t in_op;
    logic [TIME_BITS-1:0] in_time_a;
    logic [TIME_BITS-1:0] in_time_b;

    // Classify: a lookup carries its query time in the first slot
    assign in_op     = itl_op_t'(s_req_type);
    assign in_time_a = (in_op == OP_LOOKUP) ? TIME_BITS'(s_query_time)
                                            : TIME_BITS'(s_start_time);
    assign in_time_b = TIME_BITS'(s_end_time);

    assign s_ready   = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    assign cmd_op     = op_q[rd_ptr_reg];
    assign cmd_time_a = time_a_q[rd_ptr_reg];
    assign cmd_time_b = time_b_q[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            op_q[wr_ptr_reg]     <= in_op;
            time_a_q[wr_ptr_reg] <= in_time_a;
            time_b_q[wr_ptr_reg] <= in_time_b;
        end
    end

endmodule

// ===== rtl/itl_back.sv =====
`timescale 1ns / 1ps

module itl_back #(
    parameter int TABLE_DEPTH = itl_pkg::TABLE_DEPTH_DEF,
    parameter int TIME_BITS   = itl_pkg::TIME_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [itl_pkg::FIELD_LIMIT_W-1:0]   entry_limit,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  itl_pkg::itl_op_t                    cmd_op,
    input  logic [TIME_BITS-1:0]                cmd_time_a,
    input  logic [TIME_BITS-1:0]                cmd_time_b,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [itl_pkg::FIELD_STAT_W-1:0]    m_status,
    output logic                                m_match_found,
    output logic [itl_pkg::FIELD_INDEX_W-1:0]   m_match_index,
    output logic [itl_pkg::FIELD_COUNT_W-1:0]   m_entry_count,
    output logic [itl_pkg::FIELD_TIME_W-1:0]    m_earliest_start,
    output logic [itl_pkg::FIELD_TIME_W-1:0]    m_latest_end
);

    import itl_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TIME_BITS-1:0] earliest_reg, earliest_next;
    logic [TIME_BITS-1:0] latest_reg, latest_next;
    logic [TIME_BITS-1:0] query_reg, query_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;

    logic                      res_valid_reg, res_valid_next;
    logic [FIELD_STAT_W-1:0]   res_status_reg, res_status_next;
    logic                      res_found_reg, res_found_next;
    logic [FIELD_INDEX_W-1:0]  res_index_reg, res_index_next;
    logic [FIELD_COUNT_W-1:0]  res_count_reg, res_count_next;
    logic [FIELD_TIME_W-1:0]   res_earliest_reg, res_earliest_next;
    logic [FIELD_TIME_W-1:0]   res_latest_reg, res_latest_next;

    logic                     slot_free;
    logic                     pop;
    logic                     is_full;
    logic                     bad_order;
    logic                     load_ok;
    logic                     issue_en;
    logic                     hit;
    logic                     last;
    logic [2*TIME_BITS-1:0]   rd_data;
    logic [TIME_BITS-1:0]     rd_start;
    logic [TIME_BITS-1:0]     rd_end;

    assign slot_free = !res_valid_reg || m_ready;
    assign cmd_ready = (state_reg == S_IDLE) && slot_free;
    assign pop       = cmd_valid && cmd_ready;

    assign is_full   = (count_reg == CNT_W'(TABLE_DEPTH))
                    || ((entry_limit != '0) && (32'(count_reg) >= 32'(entry_limit)));
    assign bad_order = (cmd_time_a > cmd_time_b);
    assign load_ok   = pop && (cmd_op == OP_LOAD) && !is_full && !bad_order;

    assign issue_en = (state_reg == S_SCAN) && (issue_reg < count_reg);

    assign rd_start = rd_data[TIME_BITS-1:0];
    assign rd_end   = rd_data[2*TIME_BITS-1:TIME_BITS];
    assign hit      = chk_valid_reg && (query_reg >= rd_start) && (query_reg <= rd_end);
    assign last     = (CNT_W'(chk_idx_reg) == count_reg - CNT_W'(1));

    itl_ram #(
        .WIDTH (2 * TIME_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (load_ok),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({cmd_time_b, cmd_time_a}),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    always_comb begin
        state_next        = state_reg;
        count_next        = count_reg;
        earliest_next     = earliest_reg;
        latest_next       = latest_reg;
        query_next        = query_reg;
        issue_next        = issue_reg;
        chk_valid_next    = 1'b0;
        chk_idx_next      = chk_idx_reg;
        res_valid_next    = res_valid_reg && !m_ready;
        res_status_next   = res_status_reg;
        res_found_next    = res_found_reg;
        res_index_next    = res_index_reg;
        res_count_next    = res_count_reg;
        res_earliest_next = res_earliest_reg;
        res_latest_next   = res_latest_reg;

        case (state_reg)
            S_IDLE: begin
                if (pop) begin
                    res_found_next  = 1'b0;
                    res_index_next  = '0;
                    res_status_next = STAT_OK;
                    if (cmd_op == OP_LOAD) begin
                        if (is_full) begin
                            res_status_next = STAT_FULL;
                        end else if (bad_order) begin
                            res_status_next = STAT_BAD_ORDER;
                        end else begin
                            count_next = count_reg + CNT_W'(1);
                            if (count_reg == '0) begin
                                earliest_next = cmd_time_a;
                                latest_next   = cmd_time_b;
                            end else begin
                                if (cmd_time_a < earliest_reg) begin
                                    earliest_next = cmd_time_a;
                                end
                                if (cmd_time_b > latest_reg) begin
                                    latest_next = cmd_time_b;
                                end
                            end
                        end
                        res_valid_next = 1'b1;
                    end else if (count_reg == '0) begin
                        // Empty table: report no match at once
                        res_valid_next = 1'b1;
                    end else begin
                        state_next = S_SCAN;
                        query_next = cmd_time_a;
                        issue_next = '0;
                    end
                    res_count_next    = FIELD_COUNT_W'(count_next);
                    res_earliest_next = FIELD_TIME_W'(earliest_next);
                    res_latest_next   = FIELD_TIME_W'(latest_next);
                end
            end
            S_SCAN: begin
                // Issue one read per cycle; compare each entry in the cycle after its read is issued
                if (issue_en) begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                chk_valid_next = issue_en;
                chk_idx_next   = issue_reg[IDX_W-1:0];
                if (chk_valid_reg && (hit || last)) begin
                    state_next     = S_IDLE;
                    chk_valid_next = 1'b0;
                    res_valid_next = 1'b1;
                    res_found_next = hit;
                    res_index_next = hit ? FIELD_INDEX_W'(chk_idx_reg) : '0;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            earliest_reg  <= '0;
            latest_reg    <= '0;
            chk_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            earliest_reg  <= earliest_next;
            latest_reg    <= latest_next;
            chk_valid_reg <= chk_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        query_reg        <= query_next;
        issue_reg        <= issue_next;
        chk_idx_reg      <= chk_idx_next;
        res_status_reg   <= res_status_next;
        res_found_reg    <= res_found_next;
        res_index_reg    <= res_index_next;
        res_count_reg    <= res_count_next;
        res_earliest_reg <= res_earliest_next;
        res_latest_reg   <= res_latest_next;
    end

    assign m_valid          = res_valid_reg;
    assign m_status         = res_status_reg;
    assign m_match_found    = res_found_reg;
    assign m_match_index    = res_index_reg;
    assign m_entry_count    = res_count_reg;
    assign m_earliest_start = res_earliest_reg;
    assign m_latest_end     = res_latest_reg;

endmodule

// ===== rtl/interval_table_lookup.sv =====
`timescale 1ns / 1ps
// Interval table with first-hit lookup.
// Requests enter on the s_ channel (valid/ready). A load request (s_req_type 0)
// appends [s_start_time, s_end_time] if it is ordered and there is room; a lookup
// (s_req_type 1) returns the lowest index whose interval holds s_query_time.
// Exactly one result per request leaves on the m_ channel (valid/ready), in order.
// The cfg channel (valid/ready, always ready) writes entry_limit; write it only
// while no request is in flight. Zero means only the table depth limits loading.
// Requests pass through a two-entry queue into the execution part, so new
// requests are taken while a result waits or a lookup is scanning.
// A load's result is registered in the output register once the execution part takes it.
// A lookup reads one stored interval per cycle from the single read port of the
// interval memory, from index 0 upward, and ends at the first hit or after the
// last stored entry; no new request enters the execution part while it scans.
// Reset (aresetn low, synchronous) empties the table and clears entry_limit, the
// earliest start and the latest end; no clearing pass is needed.
// When the receiver stalls, the result is held in the output register, the queue
// fills, and s_ready drops once it is full.
module interval_table_lookup #(
    parameter int TABLE_DEPTH = itl_pkg::TABLE_DEPTH_DEF,
    parameter int TIME_BITS   = itl_pkg::TIME_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [itl_pkg::FIELD_LIMIT_W-1:0]   cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_req_type,
    input  logic [itl_pkg::FIELD_TIME_W-1:0]    s_start_time,
    input  logic [itl_pkg::FIELD_TIME_W-1:0]    s_end_time,
    input  logic [itl_pkg::FIELD_TIME_W-1:0]    s_query_time,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [itl_pkg::FIELD_STAT_W-1:0]    m_status,
    output logic                                m_match_found,
    output logic [itl_pkg::FIELD_INDEX_W-1:0]   m_match_index,
    output logic [itl_pkg::FIELD_COUNT_W-1:0]   m_entry_count,
    output logic [itl_pkg::FIELD_TIME_W-1:0]    m_earliest_start,
    output logic [itl_pkg::FIELD_TIME_W-1:0]    m_latest_end
);

    import itl_pkg::*;

    logic [FIELD_LIMIT_W-1:0] limit_reg;
    logic                     cmd_valid;
    logic                     cmd_ready;
    itl_op_t                  cmd_op;
    logic [TIME_BITS-1:0]     cmd_time_a;
    logic [TIME_BITS-1:0]     cmd_time_b;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= cfg_data;
        end
    end

    itl_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_start_time (s_start_time),
        .s_end_time   (s_end_time),
        .s_query_time (s_query_time),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd_op       (cmd_op),
        .cmd_time_a   (cmd_time_a),
        .cmd_time_b   (cmd_time_b)
    );

    itl_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .entry_limit      (limit_reg),
        .cmd_valid        (cmd_valid),
        .cmd_ready        (cmd_ready),
        .cmd_op           (cmd_op),
        .cmd_time_a       (cmd_time_a),
        .cmd_time_b       (cmd_time_b),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_match_found    (m_match_found),
        .m_match_index    (m_match_index),
        .m_entry_count    (m_entry_count),
        .m_earliest_start (m_earliest_start),
        .m_latest_end     (m_latest_end)
    );

endmodule
